@@ hw/rtl/bpjq_pkg.sv @@
`default_nettype none

package bpjq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;

    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_DEQUEUE = 1'b1;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_DEQUEUED  = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [31:0] job_id;
        logic [2:0]  priority_req;
        logic [31:0] job_handle;
        logic [30:0] requester;
    } job_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_job_id;
        logic [2:0]  out_priority;
        logic [31:0] out_handle;
        logic [30:0] out_requester;
        logic [4:0]  occupancy;
    } result_item_t;

    typedef struct packed {
        logic [31:0] job_id;
        logic [2:0]  prio;
        logic [31:0] handle;
        logic [30:0] requester;
    } slot_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_EVAL,
        CMD_INSERT,
        CMD_SHIFT_OUT
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_COMMIT
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/bpjq_cell.sv @@
`default_nettype none

module bpjq_cell import bpjq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire slot_t     new_slot,
    input  wire slot_t     left_slot,
    input  wire logic      left_ins,
    input  wire logic      left_valid,
    input  wire slot_t     right_slot,
    input  wire logic      right_valid,
    output slot_t          slot,
    output logic           valid,
    output logic           ins,
    output logic           match
);

    slot_t slot_reg, slot_next;
    logic  valid_reg, valid_next;
    logic  ins_reg, ins_next;
    logic  match_reg, match_next;

    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        ins_next   = ins_reg;
        match_next = match_reg;
        unique case (cmd)
            CMD_HOLD:
            begin
            end
            CMD_EVAL:
            begin
                ins_next   = !valid_reg || (new_slot.prio > slot_reg.prio);
                match_next = valid_reg && (slot_reg.job_id == new_slot.job_id);
            end
            CMD_INSERT:
            begin
                if (ins_reg)
                begin
                    slot_next  = left_ins ? left_slot : new_slot;
                    valid_next = left_ins ? left_valid : 1'b1;
                end
            end
            CMD_SHIFT_OUT:
            begin
                slot_next  = right_slot;
                valid_next = right_valid;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ins_reg   <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            ins_reg   <= ins_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot  = slot_reg;
    assign valid = valid_reg;
    assign ins   = ins_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bounded_priority_job_queue_unit.sv @@
// Bounded priority job queue, QUEUE_DEPTH entries kept sorted in a chain of
// cells, highest priority at the head, arrival order among equal priorities.
// Input channel job/job_valid/job_stall carries one enqueue or dequeue
// transaction; the output channel result/result_valid/result_stall carries
// exactly one result per accepted transaction, in order.
// An accepted transaction first passes a compare step (S_EVAL), in which every
// cell compares its entry against the new job (duplicate id and insert
// position), then a commit step (S_COMMIT), in which the cells shift and the
// result register loads. A new transaction is not accepted until the last one
// has committed; job_stall is high while it is in the compare/commit steps.
// The result register decouples the sides: a new transaction is accepted while
// a result waits. If result_stall holds, the next commit waits for the result
// register to drain, and job_stall stays high meanwhile.
// Reset clears the occupancy, all entry valid flags and result_valid; the
// queue is usable in the first cycle after reset.
`default_nettype none

module bounded_priority_job_queue_unit import bpjq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         job_valid,
    output logic              job_stall,
    input  wire job_item_t    job,
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_item_t      result
);

    state_t       state_reg, state_next;
    job_item_t    item_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    result_item_t out_reg, out_next;
    logic         out_valid_reg, out_valid_next;

    cell_cmd_t    cmd;
    logic         load_out;
    logic         can_commit;
    logic         full;
    logic         dup;
    logic         empty;

    slot_t        new_slot;
    slot_t        cell_slot [QUEUE_DEPTH];
    logic         cell_valid [QUEUE_DEPTH];
    logic         cell_ins [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_match;

    assign new_slot.job_id    = item_reg.job_id;
    assign new_slot.prio      = item_reg.priority_req;
    assign new_slot.handle    = item_reg.job_handle;
    assign new_slot.requester = item_reg.requester;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        slot_t lslot;
        logic  lins;
        logic  lvalid;
        slot_t rslot;
        logic  rvalid;

        if (i == 0)
        begin : g_head
            assign lslot  = '0;
            assign lins   = 1'b0;
            assign lvalid = 1'b0;
        end
        else
        begin : g_mid
            assign lslot  = cell_slot[i-1];
            assign lins   = cell_ins[i-1];
            assign lvalid = cell_valid[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign rslot  = '0;
            assign rvalid = 1'b0;
        end
        else
        begin : g_body
            assign rslot  = cell_slot[i+1];
            assign rvalid = cell_valid[i+1];
        end

        bpjq_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .new_slot    (new_slot),
            .left_slot   (lslot),
            .left_ins    (lins),
            .left_valid  (lvalid),
            .right_slot  (rslot),
            .right_valid (rvalid),
            .slot        (cell_slot[i]),
            .valid       (cell_valid[i]),
            .ins         (cell_ins[i]),
            .match       (cell_match[i])
        );
    end

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0) || !cell_valid[0];
    assign dup        = |cell_match;
    assign can_commit = !out_valid_reg || !result_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (can_commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        job_stall = 1'b1;
        cmd       = CMD_HOLD;
        load_out  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                job_stall = 1'b0;
            end
            S_EVAL:
            begin
                cmd = CMD_EVAL;
            end
            S_COMMIT:
            begin
                if (can_commit)
                begin
                    load_out = 1'b1;
                    if (item_reg.kind == KIND_ENQUEUE)
                    begin
                        if (!full && !dup)
                        begin
                            cmd = CMD_INSERT;
                        end
                    end
                    else if (!empty)
                    begin
                        cmd = CMD_SHIFT_OUT;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        out_next   = '0;
        if (item_reg.kind == KIND_ENQUEUE)
        begin
            priority if (full)
            begin
                out_next.status        = ST_FULL;
                out_next.out_job_id    = item_reg.job_id;
                out_next.out_requester = item_reg.requester;
            end
            else if (dup)
            begin
                out_next.status        = ST_DUPLICATE;
                out_next.out_job_id    = item_reg.job_id;
                out_next.out_requester = item_reg.requester;
            end
            else
            begin
                out_next.status = ST_ACCEPTED;
                count_next      = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                out_next.status = ST_EMPTY;
            end
            else
            begin
                out_next.status        = ST_DEQUEUED;
                out_next.out_job_id    = cell_slot[0].job_id;
                out_next.out_priority  = cell_slot[0].prio;
                out_next.out_handle    = cell_slot[0].handle;
                out_next.out_requester = cell_slot[0].requester;
                count_next             = count_reg - CNT_W'(1);
            end
        end
        out_next.occupancy = OCC_W'(count_next);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && !job_stall)
        begin
            item_reg <= job;
        end
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

@@ tb/bounded_priority_job_queue_unit_test.sv @@
`default_nettype none

module bounded_priority_job_queue_unit_test;
    import bpjq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM_JOBS = 1650;
    localparam int IDLE_LIMIT      = 3000;
    localparam int HOLD_CYCLES     = 160;
    localparam int MAX_REPORTS     = 10;

    logic         clk;
    logic         rst_n;
    logic         job_valid    = 1'b0;
    logic         job_stall;
    job_item_t    job          = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result;

    bounded_priority_job_queue_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_stall    (job_stall),
        .job          (job),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // local copy of the sorted queue
    slot_t        q_slot [QUEUE_DEPTH];
    int           q_count = 0;

    job_item_t    job_backlog[$];
    result_item_t due_results[$];
    int           total_jobs     = 0;
    int           jobs_sent      = 0;
    int           results_seen   = 0;
    int           mismatch_count = 0;
    int           idle_cycles    = 0;

    int           send_gap       = 0;
    int           stall_left     = 0;
    int           hold_left      = 0;
    int           holds_done     = 0;
    int           phase_left     = 0;
    logic         calm_phase     = 1'b0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic result_item_t sorted_queue_apply(job_item_t it);
        result_item_t r;
        int           i;
        int           pos;
        bit           dup;
        r   = '0;
        dup = 1'b0;
        if (it.kind == KIND_ENQUEUE) begin
            for (i = 0; i < q_count; i++)
                if (q_slot[i].job_id == it.job_id)
                    dup = 1'b1;
            if (q_count >= QUEUE_DEPTH) begin
                r.status        = ST_FULL;
                r.out_job_id    = it.job_id;
                r.out_requester = it.requester;
            end else if (dup) begin
                r.status        = ST_DUPLICATE;
                r.out_job_id    = it.job_id;
                r.out_requester = it.requester;
            end else begin
                pos = q_count;
                for (i = q_count - 1; i >= 0; i--)
                    if (it.priority_req > q_slot[i].prio)
                        pos = i;
                for (i = q_count; i > pos; i--)
                    q_slot[i] = q_slot[i - 1];
                q_slot[pos].job_id    = it.job_id;
                q_slot[pos].prio      = it.priority_req;
                q_slot[pos].handle    = it.job_handle;
                q_slot[pos].requester = it.requester;
                q_count++;
                r.status = ST_ACCEPTED;
            end
        end else if (q_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status        = ST_DEQUEUED;
            r.out_job_id    = q_slot[0].job_id;
            r.out_priority  = q_slot[0].prio;
            r.out_handle    = q_slot[0].handle;
            r.out_requester = q_slot[0].requester;
            for (i = 0; i + 1 < q_count; i++)
                q_slot[i] = q_slot[i + 1];
            q_count--;
        end
        r.occupancy = OCC_W'(q_count);
        return r;
    endfunction

    function automatic job_item_t make_job(logic kind, logic [31:0] id, logic [2:0] prio,
                                           logic [31:0] handle, logic [30:0] req);
        job_item_t j;
        j.kind         = kind;
        j.job_id       = id;
        j.priority_req = prio;
        j.job_handle   = handle;
        j.requester    = req;
        return j;
    endfunction

    // narrow id pool so duplicates show up; some fully random ids
    function automatic job_item_t random_job(int enq_pct, bit wide_ids);
        job_item_t j;
        j.kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQUEUE : KIND_DEQUEUE;
        if (wide_ids || $urandom_range(0, 9) == 0)
            j.job_id = $urandom;
        else
            j.job_id = 32'($urandom_range(0, 47));
        if ($urandom_range(0, 7) == 0)
            j.priority_req = 3'($urandom_range(5, 7));
        else
            j.priority_req = 3'($urandom_range(0, 4));
        j.job_handle = $urandom;
        j.requester  = 31'($urandom);
        return j;
    endfunction

    function automatic int pick_gap(logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    initial begin
        int i;
        int mode;
        int run_len;
        int enq_pct;
        int n_random;

        job_backlog.push_back(make_job(KIND_DEQUEUE, '1, 3'd7, '1, '1));
        job_backlog.push_back(make_job(KIND_ENQUEUE, 32'h0, 3'd0, 32'h0, 31'h0));
        job_backlog.push_back(make_job(KIND_ENQUEUE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF,
                                       31'h7FFF_FFFF));
        job_backlog.push_back(make_job(KIND_ENQUEUE, 32'h0, 3'd4, 32'h1234_5678, 31'h5));
        for (i = 0; i < 14; i++)
            job_backlog.push_back(make_job(KIND_ENQUEUE, 32'(100 + i), 3'(i % 5),
                                           $urandom, 31'($urandom)));
        // full and duplicate at once: full wins
        job_backlog.push_back(make_job(KIND_ENQUEUE, 32'h0, 3'd2, 32'hDEAD_BEEF, 31'h77));
        for (i = 0; i < 5; i++)
            job_backlog.push_back(make_job(KIND_DEQUEUE, $urandom, 3'($urandom),
                                           $urandom, 31'($urandom)));

        n_random = 0;
        while (n_random < NUM_RANDOM_JOBS) begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(8, 48);
            case (mode)
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            for (i = 0; i < run_len; i++)
                job_backlog.push_back(random_job(enq_pct, mode == 3));
            n_random += run_len;
        end
        total_jobs = job_backlog.size();

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (jobs_sent < total_jobs || due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && due_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            job_valid <= 1'b0;
            send_gap  <= 0;
        end else begin
            if (job_valid && !job_stall) begin
                due_results.push_back(sorted_queue_apply(job));
                jobs_sent++;
            end
            if (!job_valid || !job_stall) begin
                if (send_gap > 0) begin
                    job_valid <= 1'b0;
                    send_gap  <= send_gap - 1;
                end else if (job_backlog.size() != 0) begin
                    job       <= job_backlog.pop_front();
                    job_valid <= 1'b1;
                    send_gap  <= pick_gap(calm_phase);
                end else begin
                    job_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with long hold-offs to back up the input side
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            holds_done   <= 0;
            calm_phase   <= 1'b0;
            phase_left   <= 0;
        end else begin
            if (phase_left == 0) begin
                calm_phase <= ($urandom_range(0, 3) == 0);
                phase_left <= $urandom_range(100, 300);
            end else begin
                phase_left <= phase_left - 1;
            end

            if ((holds_done == 0 && results_seen >= 40) ||
                (holds_done == 1 && results_seen >= 900)) begin
                hold_left    <= HOLD_CYCLES;
                holds_done   <= holds_done + 1;
                result_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                result_stall <= (hold_left > 1);
            end else if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                result_stall <= 1'b1;
            end else begin
                stall_left   <= pick_gap(calm_phase);
                result_stall <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        result_item_t want;
        if (rst_n && result_valid && !result_stall) begin
            results_seen++;
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result transaction: status=%0d id=%h occ=%0d",
                             result.status, result.out_job_id, result.occupancy);
            end else begin
                want = due_results.pop_front();
                if (result.status != want.status ||
                    result.out_job_id != want.out_job_id ||
                    result.out_priority != want.out_priority ||
                    result.out_handle != want.out_handle ||
                    result.out_requester != want.out_requester ||
                    result.occupancy != want.occupancy) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch at result %0d", results_seen);
                        $display("  expected: st=%0d id=%h pr=%0d h=%h rq=%h occ=%0d",
                                 want.status, want.out_job_id, want.out_priority,
                                 want.out_handle, want.out_requester, want.occupancy);
                        $display("  actual:   st=%0d id=%h pr=%0d h=%h rq=%h occ=%0d",
                                 result.status, result.out_job_id, result.out_priority,
                                 result.out_handle, result.out_requester, result.occupancy);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((job_valid && !job_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/bpjq_pkg.sv
hw/rtl/bpjq_cell.sv
hw/rtl/bounded_priority_job_queue_unit.sv
tb/bounded_priority_job_queue_unit_test.sv
